// ----- rtl/ssrp_pkg.sv -----
`default_nettype none
package ssrp_pkg;

  localparam logic [7:0] HdrByte     = 8'hFF;
  localparam logic [7:0] MinLen      = 8'd2;
  localparam logic [7:0] MinPayload  = 8'd3;
  localparam logic [7:0] MaxLenReset = 8'd16;

  typedef enum logic [1:0] {
    KIND_START   = 2'd0,
    KIND_BYTE    = 2'd1,
    KIND_TIMEOUT = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    PH_IDLE = 3'd0,
    PH_HDR1 = 3'd1,
    PH_HDR2 = 3'd2,
    PH_ID   = 3'd3,
    PH_LEN  = 3'd4,
    PH_BODY = 3'd5
  } phase_e;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] expected_id;
    logic [7:0] rx_byte;
  } ssrp_in_t;

  typedef struct packed {
    logic        reply_ok;
    logic [15:0] position;
  } ssrp_out_t;

endpackage
`default_nettype wire

// ----- rtl/servo_status_reply_parser_core.sv -----
// A result, made by the item that ends it, is registered into the result or the skid register.
// Throughput: one item per cycle unless stalled; the parse state updates in the accepting cycle.
// A two-entry output buffer (result register plus skid register) lets input flow while a result
// is stalled; input stalls only when both entries hold results.
// Reset: asynchronous, active low; parser idle with no query armed, max length 16, buffer empty.
`default_nettype none
module servo_status_reply_parser_core
  import ssrp_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      cfg_we_i,
  input  wire logic [7:0] cfg_wdata_i,
  input  wire logic      in_valid_i,
  output logic           in_stall_o,
  input  wire ssrp_in_t  in_data_i,
  output logic           out_valid_o,
  input  wire logic      out_stall_i,
  output ssrp_out_t      out_data_o
);

  logic [7:0]  max_len_q;
  phase_e      phase_q, phase_d;
  logic [7:0]  want_id_q, want_id_d;
  logic [7:0]  got_id_q, got_id_d;
  logic [7:0]  frame_len_q, frame_len_d;
  logic [7:0]  pay_cnt_q, pay_cnt_d;
  logic [7:0]  sum_q, sum_d;
  logic [7:0]  err_q, err_d;
  logic [15:0] pos_q, pos_d;

  logic        out_valid_q, skid_valid_q;
  ssrp_out_t   out_q, skid_q;

  logic        in_acc;
  logic        out_take;
  logic        res_v;
  ssrp_out_t   res;
  logic        is_start, is_byte, is_timeout;
  logic        len_bad;
  logic        body_more;
  logic        res_ok;
  logic [7:0]  b;

  assign in_stall_o  = skid_valid_q;
  assign in_acc      = in_valid_i & ~in_stall_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign out_take    = out_valid_q & ~out_stall_i;

  assign b          = in_data_i.rx_byte;
  assign is_start   = (in_data_i.kind == KIND_START);
  assign is_byte    = (in_data_i.kind == KIND_BYTE);
  assign is_timeout = (in_data_i.kind == KIND_TIMEOUT);
  assign len_bad    = (b < MinLen) || (b > max_len_q);
  assign body_more  = (({1'b0, pay_cnt_q} + 9'd1) < {1'b0, frame_len_q});
  assign res_ok     = (got_id_q == want_id_q) && (~sum_q == b) &&
                      (pay_cnt_q >= MinPayload) && (err_q == 8'd0);

  always_comb begin
    phase_d = phase_q;
    if (in_acc) begin
      if (is_start) begin
        phase_d = PH_HDR1;
      end else if (is_timeout) begin
        phase_d = PH_IDLE;
      end else if (is_byte) begin
        unique case (phase_q)
          PH_IDLE: phase_d = PH_IDLE;
          PH_HDR1: phase_d = (b == HdrByte) ? PH_HDR2 : PH_HDR1;
          PH_HDR2: phase_d = (b == HdrByte) ? PH_ID : PH_HDR1;
          PH_ID:   phase_d = PH_LEN;
          PH_LEN:  phase_d = len_bad ? PH_HDR1 : PH_BODY;
          PH_BODY: phase_d = body_more ? PH_BODY : PH_IDLE;
          default: phase_d = PH_IDLE;
        endcase
      end
    end
  end

  always_comb begin
    want_id_d   = want_id_q;
    got_id_d    = got_id_q;
    frame_len_d = frame_len_q;
    pay_cnt_d   = pay_cnt_q;
    sum_d       = sum_q;
    err_d       = err_q;
    pos_d       = pos_q;
    res_v       = 1'b0;
    res         = '0;
    if (in_acc) begin
      if (is_start) begin
        want_id_d   = in_data_i.expected_id;
        got_id_d    = 8'd0;
        frame_len_d = 8'd0;
        pay_cnt_d   = 8'd0;
        sum_d       = 8'd0;
        err_d       = 8'd0;
        pos_d       = 16'd0;
      end else if (is_timeout) begin
        res_v = (phase_q != PH_IDLE);
      end else if (is_byte) begin
        unique case (phase_q)
          PH_ID: begin
            got_id_d = b;
            sum_d    = b;
          end
          PH_LEN: begin
            frame_len_d = b;
            if (!len_bad) begin
              sum_d     = sum_q + b;
              pay_cnt_d = 8'd0;
              err_d     = 8'd0;
              pos_d     = 16'd0;
            end
          end
          PH_BODY: begin
            if (body_more) begin
              if (pay_cnt_q == 8'd0) begin
                err_d = b;
              end else if (pay_cnt_q == 8'd1) begin
                pos_d = {b, pos_q[7:0]};
              end else if (pay_cnt_q == 8'd2) begin
                pos_d = {pos_q[15:8], b};
              end
              pay_cnt_d = pay_cnt_q + 8'd1;
              sum_d     = sum_q + b;
            end else begin
              res_v          = 1'b1;
              res.reply_ok   = res_ok;
              res.position   = res_ok ? pos_q : 16'd0;
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_len_q   <= MaxLenReset;
      phase_q     <= PH_IDLE;
      want_id_q   <= 8'd0;
      got_id_q    <= 8'd0;
      frame_len_q <= 8'd0;
      pay_cnt_q   <= 8'd0;
      sum_q       <= 8'd0;
      err_q       <= 8'd0;
      pos_q       <= 16'd0;
    end else begin
      if (cfg_we_i) begin
        max_len_q <= cfg_wdata_i;
      end
      phase_q     <= phase_d;
      want_id_q   <= want_id_d;
      got_id_q    <= got_id_d;
      frame_len_q <= frame_len_d;
      pay_cnt_q   <= pay_cnt_d;
      sum_q       <= sum_d;
      err_q       <= err_d;
      pos_q       <= pos_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (out_take) begin
        skid_valid_q <= 1'b0;
      end
    end else if (out_valid_q && !out_take) begin
      skid_valid_q <= res_v;
    end else begin
      out_valid_q <= res_v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (out_take) begin
        out_q <= skid_q;
      end
    end else if (out_valid_q && !out_take) begin
      if (res_v) begin
        skid_q <= res;
      end
    end else if (res_v) begin
      out_q <= res;
    end
  end

  a_skid_needs_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid entry held without an output entry");

  a_fail_has_zero_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_q.reply_ok) |-> (out_q.position == 16'd0))
    else $error("failed reply carries a nonzero position");

  a_result_goes_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_v |=> (phase_q == PH_IDLE))
    else $error("parser still armed after a result");

  a_armed_timeout_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && is_timeout && phase_q != PH_IDLE) |=> out_valid_q)
    else $error("timeout on an armed query lost its result");

endmodule
`default_nettype wire

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps
module tb_top;
  import ssrp_pkg::*;

  localparam logic [1:0] KIND_UNUSED = 2'd3;
  localparam int unsigned PHASE_ITEMS = 290;
  localparam int unsigned LIMIT_NS = 400_000;

  class reply_tracker;
    phase_e      parse_phase;
    logic [7:0]  max_len;
    logic [7:0]  want_id;
    logic [7:0]  got_id;
    logic [7:0]  frame_len;
    logic [7:0]  payload_cnt;
    logic [7:0]  run_sum;
    logic [7:0]  err_byte;
    logic [15:0] pos_hold;
    ssrp_out_t   expected_replies[$];
    int unsigned errors;

    function new();
      max_len = MaxLenReset;
      parse_phase = PH_IDLE;
      want_id = '0;
      errors = 0;
      clear_frame();
    endfunction

    function void clear_frame();
      got_id = '0;
      frame_len = '0;
      payload_cnt = '0;
      run_sum = '0;
      err_byte = '0;
      pos_hold = '0;
    endfunction

    function void push_reply(logic ok);
      ssrp_out_t r;
      r.reply_ok = ok;
      r.position = ok ? pos_hold : 16'd0;
      expected_replies.push_back(r);
    endfunction

    task report(input string msg);
      errors++;
      $display("%0t: reply check failed: %s", $time, msg);
    endtask

    task take_item(input ssrp_in_t it);
      logic [7:0] b;
      b = it.rx_byte;
      case (it.kind)
        KIND_START: begin
          want_id = it.expected_id;
          clear_frame();
          parse_phase = PH_HDR1;
        end
        KIND_TIMEOUT: begin
          if (parse_phase != PH_IDLE) begin
            parse_phase = PH_IDLE;
            push_reply(1'b0);
          end
        end
        KIND_BYTE: begin
          case (parse_phase)
            PH_HDR1: if (b == HdrByte) parse_phase = PH_HDR2;
            PH_HDR2: parse_phase = (b == HdrByte) ? PH_ID : PH_HDR1;
            PH_ID: begin
              got_id = b;
              run_sum = b;
              parse_phase = PH_LEN;
            end
            PH_LEN: begin
              frame_len = b;
              if (b < MinLen || b > max_len) begin
                parse_phase = PH_HDR1;
              end else begin
                run_sum = run_sum + b;
                payload_cnt = '0;
                err_byte = '0;
                pos_hold = '0;
                parse_phase = PH_BODY;
              end
            end
            PH_BODY: begin
              if ({1'b0, payload_cnt} + 9'd1 < {1'b0, frame_len}) begin
                if (payload_cnt == 8'd0) err_byte = b;
                else if (payload_cnt == 8'd1) pos_hold[15:8] = b;
                else if (payload_cnt == 8'd2) pos_hold[7:0] = b;
                payload_cnt = payload_cnt + 8'd1;
                run_sum = run_sum + b;
              end else begin
                push_reply(got_id == want_id && (run_sum ^ 8'hFF) == b &&
                           payload_cnt >= MinPayload && err_byte == 8'd0);
                parse_phase = PH_IDLE;
              end
            end
            default: ;
          endcase
        end
        default: ;
      endcase
    endtask

    task check_reply(input ssrp_out_t got);
      ssrp_out_t exp_r;
      if (expected_replies.size() == 0) begin
        report($sformatf("unexpected reply ok=%0b pos=%h", got.reply_ok, got.position));
        return;
      end
      exp_r = expected_replies.pop_front();
      if (got.reply_ok !== exp_r.reply_ok)
        report($sformatf("reply_ok %b, want %b", got.reply_ok, exp_r.reply_ok));
      if (got.position !== exp_r.position)
        report($sformatf("position %h, want %h", got.position, exp_r.position));
    endtask
  endclass

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       cfg_we_i = 1'b0;
  logic [7:0] cfg_wdata_i = '0;
  logic       in_valid_i = 1'b0;
  logic       in_stall_o;
  ssrp_in_t   in_data_i = '0;
  logic       out_valid_o;
  logic       out_stall_i = 1'b0;
  ssrp_out_t  out_data_o;

  reply_tracker tracker;
  int unsigned  send_idle_pct = 28;
  int unsigned  recv_idle_pct = 74;
  int unsigned  sent_count = 0;
  logic [7:0]   len_limit = MaxLenReset;

  servo_status_reply_parser_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < recv_idle_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) tracker.take_item(in_data_i);
      if (out_valid_o && !out_stall_i) tracker.check_reply(out_data_o);
    end
  end

  function automatic ssrp_in_t mk_item(logic [1:0] k, logic [7:0] eid, logic [7:0] b);
    ssrp_in_t it;
    it.kind = k;
    it.expected_id = eid;
    it.rx_byte = b;
    return it;
  endfunction

  task automatic send_item(input ssrp_in_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= it;
    do @(posedge clk_i); while (in_stall_o);
    sent_count++;
  endtask

  task automatic send_byte(input logic [7:0] b);
    send_item(mk_item(KIND_BYTE, 8'($urandom), b));
  endtask

  task automatic wait_for_replies();
    while (tracker.expected_replies.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_max_len(input logic [7:0] v);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    tracker.max_len = v;
    len_limit = v;
  endtask

  task automatic send_frame(input logic [7:0] qid, output bit taken);
    logic [7:0]  fid;
    logic [7:0]  flen;
    logic [7:0]  sum;
    logic [7:0]  b;
    logic [7:0]  lim;
    int unsigned pick;
    pick = $urandom_range(39);
    lim = (len_limit < 8'd8) ? len_limit : 8'd8;
    fid = ($urandom_range(4) == 0) ? 8'($urandom) : qid;
    if (pick < 3) flen = 8'($urandom_range(1));
    else if (pick < 6 && len_limit != 8'hFF) flen = 8'($urandom_range(255, len_limit + 1));
    else if (pick == 6) flen = len_limit;
    else flen = 8'($urandom_range(lim, 2));
    send_byte(HdrByte);
    send_byte(HdrByte);
    send_byte(fid);
    send_byte(flen);
    taken = (flen >= MinLen && flen <= len_limit);
    if (!taken) return;
    sum = fid + flen;
    for (int i = 0; i + 1 < flen; i++) begin
      if ($urandom_range(79) == 0) begin
        send_item(mk_item(KIND_TIMEOUT, 8'($urandom), 8'($urandom)));
        return;
      end
      b = (i == 0 && $urandom_range(4) != 0) ? 8'h00 : 8'($urandom);
      sum = sum + b;
      send_byte(b);
    end
    send_byte(($urandom_range(6) != 0) ? ~sum : 8'($urandom));
  endtask

  task automatic send_query();
    logic [7:0] qid;
    bit         taken;
    qid = 8'($urandom);
    send_item(mk_item(KIND_START, qid, 8'($urandom)));
    repeat ($urandom_range(2))
      send_byte(($urandom_range(9) == 0) ? HdrByte : 8'($urandom_range(254)));
    send_frame(qid, taken);
    if (!taken) send_frame(qid, taken);
    case ($urandom_range(19))
      0, 1: send_item(mk_item(KIND_TIMEOUT, 8'($urandom), 8'($urandom)));
      2: send_item(mk_item(KIND_UNUSED, 8'($urandom), 8'($urandom)));
      3: send_byte(8'($urandom));
      default: ;
    endcase
  endtask

  task automatic run_phase(input logic [7:0] limit, input int unsigned s_pct,
                           input int unsigned r_pct);
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    set_max_len(limit);
    sent_count = 0;
    while (sent_count < PHASE_ITEMS) send_query();
    in_valid_i <= 1'b0;
    wait_for_replies();
  endtask

  initial begin
    tracker = new();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // idle, unused kind, header faults, length rejects, bad-checksum frame, restart, timeout
    send_byte(HdrByte);
    send_item(mk_item(KIND_TIMEOUT, 8'h00, 8'h00));
    send_item(mk_item(KIND_UNUSED, 8'hFF, 8'hFF));
    send_item(mk_item(KIND_START, 8'hFF, 8'h00));
    send_byte(HdrByte);
    send_byte(8'h00);
    send_byte(HdrByte);
    send_byte(HdrByte);
    send_byte(8'hFF);
    send_byte(8'h00);
    send_byte(HdrByte);
    send_byte(HdrByte);
    send_byte(8'hFF);
    send_byte(MaxLenReset + 8'd1);
    send_byte(HdrByte);
    send_byte(HdrByte);
    send_byte(8'hFF);
    send_byte(8'h04);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'hFF);
    send_byte(8'h02);
    send_item(mk_item(KIND_START, 8'h00, 8'hFF));
    send_item(mk_item(KIND_START, 8'h00, 8'h00));
    send_item(mk_item(KIND_TIMEOUT, 8'hFF, 8'hFF));
    in_valid_i <= 1'b0;
    wait_for_replies();

    run_phase(8'hFF, 28, 74);
    run_phase(MinLen, 74, 28);
    run_phase(8'd9, 0, 0);

    repeat (8) @(posedge clk_i);
    if (tracker.errors == 0 && tracker.expected_replies.size() == 0) begin
      $display("servo_status_reply_parser_core: match");
    end else begin
      $display("servo_status_reply_parser_core: mismatch");
    end
    $finish;
  end

  initial begin
    #(LIMIT_NS);
    $display("servo_status_reply_parser_core: mismatch");
    $finish;
  end

endmodule
